// File: hdl/wfrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfrs_pkg
// Shared types and constants for the windowed frame rate statistics block.
// ----------------------------------------------------------------------------
package wfrs_pkg;

    localparam int          ITEM_W     = 64;
    localparam int          NOW_W      = 40;
    localparam int          DELTA_W    = 24;
    localparam int          RATE_W     = 24;
    localparam int          CFG_W      = 16;
    localparam int          QUO_W      = 64;
    localparam int          FIFO_DEPTH = 4;
    localparam logic [63:0] RATE_NUM   = 64'd1024000000;
    localparam logic [9:0]  US_PER_MS  = 10'd1000;

    localparam logic CFG_WINDOW_MS    = 1'b0;
    localparam logic CFG_MIN_DELTA_US = 1'b1;

    typedef struct packed {
        logic                start;
        logic [QUO_W-1:0]    num;
        logic [DELTA_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUO_W-1:0]    quo;
    } div_rsp_t;

endpackage
`default_nettype wire

// File: hdl/wfrs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfrs_fifo
// Short request queue between the classifying front and the compute back.
// ----------------------------------------------------------------------------
module wfrs_fifo (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire logic [wfrs_pkg::ITEM_W-1:0] push_data,
    output logic                             full,
    input  wire logic                        pop,
    output logic [wfrs_pkg::ITEM_W-1:0]      pop_data,
    output logic                             empty
);

    localparam int PTR_W = $clog2(wfrs_pkg::FIFO_DEPTH);

    logic [wfrs_pkg::ITEM_W-1:0] mem_reg [wfrs_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]            wr_ptr_reg;
    logic [PTR_W-1:0]            rd_ptr_reg;
    logic [PTR_W:0]              fill_reg;

    logic do_push;
    logic do_pop;

    assign full     = (fill_reg == (PTR_W+1)'(wfrs_pkg::FIFO_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/wfrs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfrs_front
// Accepts frame events and queues only those whose duration passes the limit.
// ----------------------------------------------------------------------------
module wfrs_front (
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [wfrs_pkg::ITEM_W-1:0] s_axis_tdata,
    input  wire logic [wfrs_pkg::CFG_W-1:0]  min_delta_us,
    output logic                             push,
    output logic [wfrs_pkg::ITEM_W-1:0]      push_data,
    input  wire logic                        fifo_full
);

    logic [wfrs_pkg::DELTA_W-1:0] delta;

    assign delta         = s_axis_tdata[wfrs_pkg::ITEM_W-1:wfrs_pkg::NOW_W];
    assign s_axis_tready = !fifo_full;
    // short frames are dropped here and never reach the back end
    assign push          = s_axis_tvalid && !fifo_full &&
                           (delta > wfrs_pkg::DELTA_W'(min_delta_us));
    assign push_data     = s_axis_tdata;

endmodule
`default_nettype wire

// File: hdl/wfrs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfrs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wfrs_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wfrs_pkg::div_req_t req,
    output wfrs_pkg::div_rsp_t      rsp
);

    localparam int DW = wfrs_pkg::DELTA_W;
    localparam int QW = wfrs_pkg::QUO_W;

    logic [QW-1:0]          num_reg;
    logic [QW-1:0]          quo_reg;
    logic [DW-1:0]          den_reg;
    logic [DW-1:0]          rem_reg;
    logic [$clog2(QW)-1:0]  cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [DW:0] rem_sh;
    logic [DW:0] rem_sub;
    logic        ge;

    assign rem_sh  = {rem_reg, num_reg[QW-1]};
    assign ge      = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == $clog2(QW)'(QW-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[QW-2:0], 1'b0};
            rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// File: hdl/wfrs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfrs_back
// Sample ring, eviction, sum and deviation passes, divides and square root.
// ----------------------------------------------------------------------------
module wfrs_back #(
    parameter int MAX_SAMPLES = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [wfrs_pkg::CFG_W-1:0]  window_ms,
    input  wire logic                        fifo_valid,
    input  wire logic [wfrs_pkg::ITEM_W-1:0] fifo_data,
    output logic                             fifo_pop,
    output wfrs_pkg::div_req_t               div_req,
    input  wire wfrs_pkg::div_rsp_t          div_rsp,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [63:0]                      m_axis_tdata
);

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int CW    = (CNT_W > 9) ? CNT_W : 9;
    localparam int NW    = wfrs_pkg::NOW_W;
    localparam int RW    = wfrs_pkg::RATE_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDIV,
        ST_INSERT,
        ST_EV_RD,
        ST_EV_CMP,
        ST_SUM,
        ST_MEAN,
        ST_DEV,
        ST_VAR,
        ST_SQRT,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [NW-1:0]            now_reg;
    logic [RW-1:0]            rate_reg;
    logic [IDX_W-1:0]         oldest_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [IDX_W-1:0]         scan_reg;
    logic [CNT_W-1:0]         issue_reg;
    logic                     pend_reg;
    logic [47:0]              prod_reg;
    logic                     prod_v_reg;
    logic [63:0]              acc_reg;
    logic [RW-1:0]            mean_reg;
    logic [63:0]              sq_val_reg;
    logic [32:0]              sq_rem_reg;
    logic [31:0]              sq_root_reg;
    logic [4:0]               sq_cnt_reg;
    wfrs_pkg::div_req_t       div_req_reg;
    logic                     m_valid_reg;
    logic [63:0]              m_data_reg;

    logic [NW-1:0]            time_mem [MAX_SAMPLES];
    logic [RW-1:0]            rate_mem [MAX_SAMPLES];
    logic [NW-1:0]            rd_time_reg;
    logic [RW-1:0]            rd_rate_reg;

    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         ins_slot;
    logic [IDX_W:0]           ins_sum;
    logic                     mem_we;
    logic [25:0]              win;
    logic                     too_old;
    logic [RW-1:0]            diff;
    logic [34:0]              rem_sh;
    logic [34:0]              trial;
    logic                     sq_ge;
    logic [CW-1:0]            cnt_ext;
    logic [8:0]               cnt_sat;
    logic [RW-1:0]            sd_sat;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
        if (s == IDX_W'(MAX_SAMPLES - 1))
        begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    assign fifo_pop      = (state_reg == ST_IDLE) && fifo_valid;
    assign div_req       = div_req_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign ins_sum  = {1'b0, oldest_reg} + (IDX_W+1)'(count_reg);
    assign ins_slot = (ins_sum >= (IDX_W+1)'(MAX_SAMPLES)) ?
                      IDX_W'(ins_sum - (IDX_W+1)'(MAX_SAMPLES)) : ins_sum[IDX_W-1:0];
    assign mem_we   = (state_reg == ST_INSERT);

    assign win     = 26'(window_ms) * 26'(wfrs_pkg::US_PER_MS);
    assign too_old = ({1'b0, rd_time_reg} + (NW+1)'(win)) < {1'b0, now_reg};
    assign diff    = (rd_rate_reg >= mean_reg) ? rd_rate_reg - mean_reg
                                               : mean_reg - rd_rate_reg;

    assign rem_sh = {sq_rem_reg, sq_val_reg[63:62]};
    assign trial  = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge  = (rem_sh >= trial);

    assign cnt_ext = CW'(count_reg);
    assign cnt_sat = (cnt_ext > CW'(511)) ? 9'd511 : cnt_ext[8:0];
    assign sd_sat  = (|sq_root_reg[31:RW]) ? {RW{1'b1}} : sq_root_reg[RW-1:0];

    always_comb
    begin
        unique case (state_reg)
            ST_SUM, ST_DEV: rd_addr = scan_reg;
            default:        rd_addr = oldest_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            time_mem[ins_slot] <= now_reg;
            rate_mem[ins_slot] <= rate_reg;
        end
        rd_time_reg <= time_mem[rd_addr];
        rd_rate_reg <= rate_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            oldest_reg  <= '0;
            count_reg   <= '0;
            scan_reg    <= '0;
            issue_reg   <= '0;
            pend_reg    <= 1'b0;
            prod_v_reg  <= 1'b0;
            div_req_reg <= '0;
            m_valid_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            prod_reg          <= 48'(diff) * 48'(diff);
            prod_v_reg        <= (state_reg == ST_DEV) && pend_reg;
            if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (fifo_valid)
                    begin
                        now_reg           <= fifo_data[NW-1:0];
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= wfrs_pkg::RATE_NUM;
                        div_req_reg.den   <= fifo_data[wfrs_pkg::ITEM_W-1:NW];
                        state_reg         <= ST_RDIV;
                    end
                end
                ST_RDIV:
                begin
                    if (div_rsp.done)
                    begin
                        rate_reg <= (|div_rsp.quo[63:RW]) ? {RW{1'b1}}
                                                          : div_rsp.quo[RW-1:0];
                        if (count_reg == CNT_W'(MAX_SAMPLES))
                        begin
                            oldest_reg <= next_slot(oldest_reg);
                            count_reg  <= CNT_W'(MAX_SAMPLES - 1);
                        end
                        state_reg <= ST_INSERT;
                    end
                end
                ST_INSERT:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= ST_EV_RD;
                end
                ST_EV_RD:
                begin
                    state_reg <= ST_EV_CMP;
                end
                ST_EV_CMP:
                begin
                    if ((count_reg != '0) && too_old)
                    begin
                        oldest_reg <= next_slot(oldest_reg);
                        count_reg  <= count_reg - 1'b1;
                        state_reg  <= ST_EV_RD;
                    end
                    else
                    begin
                        scan_reg  <= oldest_reg;
                        issue_reg <= '0;
                        pend_reg  <= 1'b0;
                        acc_reg   <= '0;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    pend_reg <= (issue_reg != count_reg);
                    if (issue_reg != count_reg)
                    begin
                        scan_reg  <= next_slot(scan_reg);
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (pend_reg)
                    begin
                        acc_reg <= acc_reg + 64'(rd_rate_reg);
                    end
                    if ((issue_reg == count_reg) && !pend_reg)
                    begin
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= acc_reg;
                        div_req_reg.den   <= wfrs_pkg::DELTA_W'(count_reg);
                        state_reg         <= ST_MEAN;
                    end
                end
                ST_MEAN:
                begin
                    if (div_rsp.done)
                    begin
                        mean_reg  <= div_rsp.quo[RW-1:0];
                        scan_reg  <= oldest_reg;
                        issue_reg <= '0;
                        pend_reg  <= 1'b0;
                        acc_reg   <= '0;
                        state_reg <= ST_DEV;
                    end
                end
                ST_DEV:
                begin
                    pend_reg <= (issue_reg != count_reg);
                    if (issue_reg != count_reg)
                    begin
                        scan_reg  <= next_slot(scan_reg);
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (prod_v_reg)
                    begin
                        acc_reg <= acc_reg + 64'(prod_reg);
                    end
                    if ((issue_reg == count_reg) && !pend_reg && !prod_v_reg)
                    begin
                        if (count_reg > CNT_W'(1))
                        begin
                            div_req_reg.start <= 1'b1;
                            div_req_reg.num   <= acc_reg;
                            div_req_reg.den   <= wfrs_pkg::DELTA_W'(count_reg - 1'b1);
                            state_reg         <= ST_VAR;
                        end
                        else
                        begin
                            sq_val_reg  <= acc_reg;
                            sq_rem_reg  <= '0;
                            sq_root_reg <= '0;
                            sq_cnt_reg  <= '0;
                            state_reg   <= ST_SQRT;
                        end
                    end
                end
                ST_VAR:
                begin
                    if (div_rsp.done)
                    begin
                        sq_val_reg  <= div_rsp.quo;
                        sq_rem_reg  <= '0;
                        sq_root_reg <= '0;
                        sq_cnt_reg  <= '0;
                        state_reg   <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    sq_rem_reg  <= sq_ge ? 33'(rem_sh - trial) : rem_sh[32:0];
                    sq_root_reg <= {sq_root_reg[30:0], sq_ge};
                    sq_val_reg  <= {sq_val_reg[61:0], 2'b00};
                    sq_cnt_reg  <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 5'd31)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {7'b0, cnt_sat, sd_sat, mean_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hdl/windowed_frame_rate_statistics.sv
`timescale 1ns / 1ps
`default_nettype none
// Per kept event: a rate divide, eviction checks, a sum pass, a mean divide, a deviation pass,
//   a variance divide when more than one sample is held, and a 32-step square root.
// Throughput: one event at a time in the back end; the queue holds up to four.
// Short-duration events are dropped at the front and take no back-end time.
// Reset: asynchronous, active low; ring empty, window 1000 ms, min delta 100 us.
// ----------------------------------------------------------------------------
// windowed_frame_rate_statistics
// Sliding-window mean and sample standard deviation of frame rate.
// ----------------------------------------------------------------------------
module windowed_frame_rate_statistics #(
    parameter int MAX_SAMPLES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // frame event requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [39:0] now_us, [63:40] delta_us
    // statistics results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata    // [23:0] mean_fps, [47:24] fps_std_dev,
                                             // [56:48] sample_count, rest zero
);

    logic [15:0]                 window_ms_reg;
    logic [15:0]                 min_delta_reg;

    // front to queue
    logic                        push;
    logic [wfrs_pkg::ITEM_W-1:0] push_data;
    logic                        fifo_full;
    // queue to back
    logic                        fifo_pop;
    logic                        fifo_empty;
    logic [wfrs_pkg::ITEM_W-1:0] fifo_data;
    // back to shared divider
    wfrs_pkg::div_req_t          div_req;
    wfrs_pkg::div_rsp_t          div_rsp;

    // Config must only be written while idle, so both halves see it settled; the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg <= 16'd1000;
            min_delta_reg <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wfrs_pkg::CFG_WINDOW_MS:    window_ms_reg <= cfg_wdata;
                wfrs_pkg::CFG_MIN_DELTA_US: min_delta_reg <= cfg_wdata;
                default:                    window_ms_reg <= window_ms_reg;
            endcase
        end
    end

    // classify and accept
    wfrs_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .min_delta_us  (min_delta_reg),
        .push          (push),
        .push_data     (push_data),
        .fifo_full     (fifo_full)
    );

    // decouples the front from the long back-end sequence
    wfrs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (fifo_data),
        .empty     (fifo_empty)
    );

    // rate divide, mean divide and variance divide all share this unit
    wfrs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ring buffer, eviction, passes and square root; holds the result register
    wfrs_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_ms     (window_ms_reg),
        .fifo_valid    (!fifo_empty),
        .fifo_data     (fifo_data),
        .fifo_pop      (fifo_pop),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire
